/* design/rpa_pkg.sv */
package rpa_pkg;

   localparam int MULQ_IN_W   = 35;
   localparam int MULQ_PROD_W = 2 * MULQ_IN_W;
   localparam int MULQ_OUT_W  = 41;

   localparam logic [63:0]        PI_Q60  = 64'h3243F6A8885A308D;
   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

   localparam int TAYLOR_TERMS    = 6;
   localparam int SQRT_STEPS      = 32;
   localparam int DIV_STEPS       = 31;
   localparam int STEPS_PER_STAGE = 4;

   typedef logic [63:0] u64_type;

   // taylor step divisors and their exact reciprocals, m = ceil(2^s / d), for x below 2^31
   localparam u64_type SIN_DIV [TAYLOR_TERMS] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};
   localparam int      SIN_SHIFT [TAYLOR_TERMS] = '{34, 36, 37, 38, 38, 39};
   localparam u64_type SIN_RECIP [TAYLOR_TERMS] = '{
      ((64'd1 << 34) + 64'd5) / 64'd6,
      ((64'd1 << 36) + 64'd19) / 64'd20,
      ((64'd1 << 37) + 64'd41) / 64'd42,
      ((64'd1 << 38) + 64'd71) / 64'd72,
      ((64'd1 << 38) + 64'd109) / 64'd110,
      ((64'd1 << 39) + 64'd155) / 64'd156
   };

   localparam u64_type COS_DIV [TAYLOR_TERMS] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132};
   localparam int      COS_SHIFT [TAYLOR_TERMS] = '{32, 35, 36, 37, 38, 39};
   localparam u64_type COS_RECIP [TAYLOR_TERMS] = '{
      ((64'd1 << 32) + 64'd1) / 64'd2,
      ((64'd1 << 35) + 64'd11) / 64'd12,
      ((64'd1 << 36) + 64'd29) / 64'd30,
      ((64'd1 << 37) + 64'd55) / 64'd56,
      ((64'd1 << 38) + 64'd89) / 64'd90,
      ((64'd1 << 39) + 64'd131) / 64'd132
   };

   typedef struct packed {
      logic [35:0] rem;
      logic [31:0] root;
   } sqrt_state_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [30:0] quo;
      logic [30:0] low;
   } div_state_type;

   // product rounded half away from zero after a shift of 30
   function automatic logic signed [MULQ_OUT_W-1:0] mulq(logic signed [MULQ_IN_W-1:0] a,
                                                         logic signed [MULQ_IN_W-1:0] b);
      logic [MULQ_IN_W-1:0]   ua;
      logic [MULQ_IN_W-1:0]   ub;
      logic [MULQ_PROD_W-1:0] pr;
      logic [MULQ_OUT_W-1:0]  mg;
      ua = a[MULQ_IN_W-1] ? MULQ_IN_W'(-a) : MULQ_IN_W'(a);
      ub = b[MULQ_IN_W-1] ? MULQ_IN_W'(-b) : MULQ_IN_W'(b);
      pr = MULQ_PROD_W'(ua) * MULQ_PROD_W'(ub);
      pr = pr + (MULQ_PROD_W'(1) << 29);
      mg = MULQ_OUT_W'(pr >> 30);
      return (a[MULQ_IN_W-1] ^ b[MULQ_IN_W-1]) ? -$signed(mg) : $signed(mg);
   endfunction

   // one root bit per call, two radicand bits in
   function automatic sqrt_state_type sqrt_step(sqrt_state_type st, logic [1:0] bits);
      logic [35:0]    cur;
      logic [35:0]    trial;
      sqrt_state_type nx;
      cur   = {st.rem[33:0], bits};
      trial = {2'b00, st.root, 2'b01};
      if (cur >= trial) begin
         nx.rem  = cur - trial;
         nx.root = {st.root[30:0], 1'b1};
      end else begin
         nx.rem  = cur;
         nx.root = {st.root[30:0], 1'b0};
      end
      return nx;
   endfunction

   // one quotient bit per call, restoring
   function automatic div_state_type div_step(div_state_type st, logic [31:0] dvs);
      logic [32:0]   cur;
      div_state_type nx;
      cur    = {st.rem, st.low[30]};
      nx.low = {st.low[29:0], 1'b0};
      if (cur >= {1'b0, dvs}) begin
         nx.rem = 32'(cur - {1'b0, dvs});
         nx.quo = {st.quo[29:0], 1'b1};
      end else begin
         nx.rem = cur[31:0];
         nx.quo = {st.quo[29:0], 1'b0};
      end
      return nx;
   endfunction

endpackage

/* design/rotate_point_about_axis.sv */
// channel  dir  handshake            payload
// req      in   req_tvalid/tready    tdata: a xyz, b xyz, point xyz, angle_deg
// rsp      out  rsp_tvalid/tready    tdata: rotated xyz; tuser: degenerate_axis
//
// one item per cycle sustained while rsp_tready stays high
// latency is set by the square root (8 stages) and the axis divider (8 stages) in series
// reset clears the stage valid bits only, no clearing pass
// a stalled stage holds while empty stages behind it keep filling, so bubbles close up
// and while a result waits in the output stage, the input accepts until all stages fill
module rotate_point_about_axis #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, point_x, point_y, point_z, angle_deg, zero pad
   input  logic [((9*COORD_WIDTH+FRAC_BITS+10+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // rotated_x, rotated_y, rotated_z, zero pad
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // degenerate_axis
   output logic [0:0] rsp_tuser
);
   import rpa_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int AW    = FRAC_BITS + 10;
   localparam int RSP_W = ((3*CW+7)/8)*8;
   localparam int PW    = $clog2(CW);
   localparam int EW    = (CW > 31) ? CW : 31;
   localparam int PRW   = CW + 5;
   localparam int RW    = CW + 7;

   localparam int ST_DIFF      = 1;
   localparam int ST_QUAD      = 2;
   localparam int ST_MSB       = 3;
   localparam int ST_NORM      = 4;
   localparam int ST_SQUARE    = 5;
   localparam int ST_SUM       = 6;
   localparam int ST_SQRT0     = 7;
   localparam int ST_SQRT_LAST = ST_SQRT0 + SQRT_STEPS/STEPS_PER_STAGE - 1;
   localparam int ST_DIVIN     = ST_SQRT_LAST + 1;
   localparam int ST_DIV0      = ST_DIVIN + 1;
   localparam int ST_DIV_LAST  = ST_DIV0 + (DIV_STEPS+STEPS_PER_STAGE-1)/STEPS_PER_STAGE - 1;
   localparam int ST_TAYLOR0   = ST_SQUARE;
   localparam int ST_TRIG      = ST_TAYLOR0 + 2*TAYLOR_TERMS;
   localparam int ST_UNIT      = ST_DIV_LAST + 1;
   localparam int ST_SU        = ST_UNIT + 1;
   localparam int ST_UU        = ST_SU + 1;
   localparam int ST_MAT       = ST_UU + 1;
   localparam int ST_PROD      = ST_MAT + 1;
   localparam int ST_OUT       = ST_PROD + 1;
   localparam int NSTAGE       = ST_OUT + 1;

   localparam logic signed [AW+1:0] DEG45  = (AW+2)'(64'd45 << FRAC_BITS);
   localparam logic signed [AW+1:0] DEG90  = (AW+2)'(64'd90 << FRAC_BITS);
   localparam logic signed [AW+1:0] DEG180 = (AW+2)'(64'd180 << FRAC_BITS);
   localparam logic signed [AW+1:0] DEG270 = (AW+2)'(64'd270 << FRAC_BITS);
   localparam logic signed [AW+1:0] DEG360 = (AW+2)'(64'd360 << FRAC_BITS);
   localparam logic signed [AW+1:0] DEG720 = (AW+2)'(64'd720 << FRAC_BITS);
   localparam logic [63:0] DEG_TO_RAD_K =
      ((PI_Q60 / 64'd180) + (64'd1 << (3 + FRAC_BITS))) >> (4 + FRAC_BITS);
   localparam logic signed [RW-1:0] SAT_HI = RW'((64'd1 << (CW-1)) - 64'd1);
   localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

   typedef struct {
      logic signed [CW-1:0] a [3];
      logic signed [CW-1:0] b [3];
      logic signed [CW-1:0] p [3];
      logic signed [AW-1:0] ang;
      logic [AW-1:0]        ared;
      logic signed [CW:0]   d [3];
      logic signed [CW:0]   v [3];
      logic [CW-1:0]        e [3];
      logic [CW-1:0]        mx;
      logic                 degen;
      logic [PW-1:0]        msb;
      logic [1:0]           quad;
      logic                 swap;
      logic [AW-1:0]        tf;
      logic [29:0]          t;
      logic [29:0]          t2;
      logic [30:0]          en [3];
      logic [61:0]          sq [3];
      logic [63:0]          sqsrc;
      sqrt_state_type       sqs;
      div_state_type        dv [3];
      logic [30:0]          xs;
      logic [30:0]          xc;
      logic signed [31:0]   st;
      logic signed [31:0]   ct;
      logic signed [31:0]   ss;
      logic signed [31:0]   cs;
      logic signed [31:0]   s;
      logic signed [31:0]   c;
      logic signed [32:0]   oc;
      logic signed [31:0]   u [3];
      logic signed [32:0]   su [3];
      logic signed [32:0]   ocu [3];
      logic signed [32:0]   uu [6];
      logic signed [33:0]   m [9];
      logic signed [PRW-1:0] pr [9];
      logic signed [CW-1:0] rot [3];
   } pipe_type;

   function automatic pipe_type load(logic [((9*CW+AW+7)/8)*8-1:0] data);
      pipe_type q;
      q = '{default: '0};
      for (int i = 0; i < 3; i++) begin
         q.a[i] = data[i*CW +: CW];
         q.b[i] = data[(3+i)*CW +: CW];
         q.p[i] = data[(6+i)*CW +: CW];
      end
      q.ang = data[9*CW +: AW];
      return q;
   endfunction

   function automatic pipe_type advance(int g, pipe_type p);
      pipe_type               q;
      logic signed [AW+1:0]   ax;
      logic signed [AW+1:0]   f;
      logic [EW-1:0]          ex;
      logic [61:0]            nf;
      logic [63:0]            src;
      logic [63:0]            prod;
      logic [31:0]            stn;
      logic [31:0]            ctn;
      logic signed [31:0]     sn;
      logic signed [31:0]     cn;
      logic signed [31:0]     uq;
      logic signed [RW-1:0]   sum;
      sqrt_state_type         sqs;
      int                     k;
      q = p;
      if (g == ST_DIFF) begin
         for (int i = 0; i < 3; i++) begin
            q.d[i] = (CW+1)'(p.b[i]) - (CW+1)'(p.a[i]);
            q.v[i] = (CW+1)'(p.p[i]) - (CW+1)'(p.a[i]);
            q.e[i] = q.d[i][CW] ? CW'(-q.d[i]) : CW'(q.d[i]);
         end
         // the field spans about plus or minus 512 degrees, so at most two wraps
         ax = (AW+2)'(p.ang);
         if (ax < -DEG360) ax = ax + DEG720;
         else if (ax < 0) ax = ax + DEG360;
         else if (ax >= DEG360) ax = ax - DEG360;
         q.ared = AW'(ax);
      end
      if (g == ST_QUAD) begin
         q.mx = p.e[0];
         if (p.e[1] > q.mx) q.mx = p.e[1];
         if (p.e[2] > q.mx) q.mx = p.e[2];
         q.degen = (q.mx == '0);
         ax = $signed({2'b00, p.ared});
         if (ax >= DEG270) begin
            q.quad = 2'd3;
            f = ax - DEG270;
         end else if (ax >= DEG180) begin
            q.quad = 2'd2;
            f = ax - DEG180;
         end else if (ax >= DEG90) begin
            q.quad = 2'd1;
            f = ax - DEG90;
         end else begin
            q.quad = 2'd0;
            f = ax;
         end
         q.swap = (f > DEG45);
         q.tf   = q.swap ? AW'(DEG90 - f) : AW'(f);
      end
      if (g == ST_MSB) begin
         q.msb = '0;
         for (int b = 0; b < CW; b++)
            if (p.mx[b]) q.msb = PW'(b);
         q.t = 30'((64'(p.tf) * DEG_TO_RAD_K + (64'd1 << 25)) >> 26);
      end
      if (g == ST_NORM) begin
         // bring the largest magnitude into [2^30, 2^31)
         for (int i = 0; i < 3; i++) begin
            ex = EW'(p.e[i]);
            if (p.msb >= 30) q.en[i] = 31'(ex >> (p.msb - 30));
            else q.en[i] = 31'(ex << (30 - p.msb));
         end
         q.t2 = 30'(mulq(MULQ_IN_W'(p.t), MULQ_IN_W'(p.t)));
         q.st = $signed({2'b00, p.t});
         q.ss = $signed({2'b00, p.t});
         q.ct = ONE_Q30;
         q.cs = ONE_Q30;
      end
      if (g == ST_SQUARE) begin
         for (int i = 0; i < 3; i++)
            q.sq[i] = 62'(p.en[i]) * 62'(p.en[i]);
      end
      if (g == ST_SUM) begin
         q.sqsrc = 64'(p.sq[0]) + 64'(p.sq[1]) + 64'(p.sq[2]);
      end
      // taylor terms: a product stage then a constant-divide stage per term
      if (g >= ST_TAYLOR0 && g < ST_TRIG && ((g - ST_TAYLOR0) % 2) == 0) begin
         k = (g - ST_TAYLOR0) / 2;
         q.xs = 31'(mulq(MULQ_IN_W'(p.st), MULQ_IN_W'(p.t2))) + 31'(SIN_DIV[k] >> 1);
         q.xc = 31'(mulq(MULQ_IN_W'(p.ct), MULQ_IN_W'(p.t2))) + 31'(COS_DIV[k] >> 1);
      end
      if (g > ST_TAYLOR0 && g <= ST_TRIG - 1 && ((g - ST_TAYLOR0) % 2) == 1) begin
         k = (g - ST_TAYLOR0 - 1) / 2;
         prod = 64'(p.xs) * 64'(SIN_RECIP[k][31:0]);
         stn  = 32'(prod >> SIN_SHIFT[k]);
         prod = 64'(p.xc) * 64'(COS_RECIP[k][31:0]);
         ctn  = 32'(prod >> COS_SHIFT[k]);
         q.st = $signed(stn);
         q.ct = $signed(ctn);
         if ((k % 2) == 0) begin
            q.ss = p.ss - $signed(stn);
            q.cs = p.cs - $signed(ctn);
         end else begin
            q.ss = p.ss + $signed(stn);
            q.cs = p.cs + $signed(ctn);
         end
      end
      if (g >= ST_SQRT0 && g <= ST_SQRT_LAST) begin
         sqs = (g == ST_SQRT0) ? '0 : p.sqs;
         src = p.sqsrc;
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            sqs = sqrt_step(sqs, src[63:62]);
            src = src << 2;
         end
         q.sqs   = sqs;
         q.sqsrc = src;
      end
      if (g == ST_DIVIN) begin
         // numerator e*2^30 + n/2; its top 31 bits already lie below n
         for (int i = 0; i < 3; i++) begin
            nf = (62'(p.en[i]) << 30) + 62'(p.sqs.root >> 1);
            q.dv[i].rem = {1'b0, nf[61:31]};
            q.dv[i].quo = '0;
            q.dv[i].low = nf[30:0];
         end
      end
      if (g >= ST_DIV0 && g <= ST_DIV_LAST) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < STEPS_PER_STAGE; j++)
               if (STEPS_PER_STAGE * (g - ST_DIV0) + j < DIV_STEPS)
                  q.dv[i] = div_step(q.dv[i], p.sqs.root);
      end
      if (g == ST_TRIG) begin
         sn = p.swap ? p.cs : p.ss;
         cn = p.swap ? p.ss : p.cs;
         case (p.quad)
            2'd0: begin q.s = sn;  q.c = cn;  end
            2'd1: begin q.s = cn;  q.c = -sn; end
            2'd2: begin q.s = -sn; q.c = -cn; end
            default: begin q.s = -cn; q.c = sn; end
         endcase
         q.oc = 33'(ONE_Q30) - 33'(q.c);
      end
      if (g == ST_UNIT) begin
         for (int i = 0; i < 3; i++) begin
            uq = $signed({1'b0, p.dv[i].quo});
            q.u[i] = p.d[i][CW] ? -uq : uq;
         end
      end
      if (g == ST_SU) begin
         for (int i = 0; i < 3; i++) begin
            q.su[i]  = 33'(mulq(MULQ_IN_W'(p.s), MULQ_IN_W'(p.u[i])));
            q.ocu[i] = 33'(mulq(MULQ_IN_W'(p.oc), MULQ_IN_W'(p.u[i])));
         end
      end
      if (g == ST_UU) begin
         q.uu[0] = 33'(mulq(MULQ_IN_W'(p.ocu[0]), MULQ_IN_W'(p.u[0])));
         q.uu[1] = 33'(mulq(MULQ_IN_W'(p.ocu[1]), MULQ_IN_W'(p.u[1])));
         q.uu[2] = 33'(mulq(MULQ_IN_W'(p.ocu[2]), MULQ_IN_W'(p.u[2])));
         q.uu[3] = 33'(mulq(MULQ_IN_W'(p.ocu[0]), MULQ_IN_W'(p.u[1])));
         q.uu[4] = 33'(mulq(MULQ_IN_W'(p.ocu[0]), MULQ_IN_W'(p.u[2])));
         q.uu[5] = 33'(mulq(MULQ_IN_W'(p.ocu[1]), MULQ_IN_W'(p.u[2])));
      end
      if (g == ST_MAT) begin
         // uu holds xx, yy, zz, xy, xz, yz
         q.m[0] = 34'(p.c) + 34'(p.uu[0]);
         q.m[1] = 34'(p.uu[3]) - 34'(p.su[2]);
         q.m[2] = 34'(p.uu[4]) + 34'(p.su[1]);
         q.m[3] = 34'(p.uu[3]) + 34'(p.su[2]);
         q.m[4] = 34'(p.c) + 34'(p.uu[1]);
         q.m[5] = 34'(p.uu[5]) - 34'(p.su[0]);
         q.m[6] = 34'(p.uu[4]) - 34'(p.su[1]);
         q.m[7] = 34'(p.uu[5]) + 34'(p.su[0]);
         q.m[8] = 34'(p.c) + 34'(p.uu[2]);
      end
      if (g == ST_PROD) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               q.pr[3*i+j] = PRW'(mulq(MULQ_IN_W'(p.m[3*i+j]), MULQ_IN_W'(p.v[j])));
      end
      if (g == ST_OUT) begin
         for (int i = 0; i < 3; i++) begin
            sum = RW'(p.a[i]) + RW'(p.pr[3*i]) + RW'(p.pr[3*i+1]) + RW'(p.pr[3*i+2]);
            if (sum > SAT_HI) sum = SAT_HI;
            if (sum < SAT_LO) sum = SAT_LO;
            q.rot[i] = p.degen ? p.p[i] : CW'(sum);
         end
      end
      return q;
   endfunction

   pipe_type            stg_ff [NSTAGE];
   pipe_type            stg_in [NSTAGE];
   logic [NSTAGE-1:0]   vld_ff;
   logic [NSTAGE-1:0]   vld_in;
   logic [NSTAGE:0]     rdy;

   // a stage takes a beat when it is empty or its successor moves
   always_comb begin
      rdy[NSTAGE] = rsp_tready;
      for (int k = NSTAGE - 1; k >= 0; k--)
         rdy[k] = !vld_ff[k] || rdy[k+1];
   end

   for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
      if (g == 0) begin : g_first
         always_comb begin
            stg_in[g] = load(req_tdata);
            vld_in[g] = req_tvalid;
         end
      end else begin : g_rest
         always_comb begin
            stg_in[g] = advance(g, stg_ff[g-1]);
            vld_in[g] = vld_ff[g-1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[g]) stg_ff[g] <= stg_in[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++)
            if (rdy[k]) vld_ff[k] <= vld_in[k];
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[NSTAGE-1];
   assign rsp_tdata  = RSP_W'({stg_ff[NSTAGE-1].rot[2], stg_ff[NSTAGE-1].rot[1],
                               stg_ff[NSTAGE-1].rot[0]});
   assign rsp_tuser  = stg_ff[NSTAGE-1].degen;

   a_degen_passes_point: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         stg_ff[NSTAGE-1].rot[0] == stg_ff[NSTAGE-1].p[0] &&
         stg_ff[NSTAGE-1].rot[1] == stg_ff[NSTAGE-1].p[1] &&
         stg_ff[NSTAGE-1].rot[2] == stg_ff[NSTAGE-1].p[2])
      else $error("degenerate axis result differs from input point");

   a_root_normalized: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_SQRT_LAST] && !stg_ff[ST_SQRT_LAST].degen |->
         stg_ff[ST_SQRT_LAST].sqs.root >= (32'd1 << 30))
      else $error("axis length root below normalized range");

   a_unit_bounded: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_DIV_LAST] && !stg_ff[ST_DIV_LAST].degen |->
         stg_ff[ST_DIV_LAST].dv[0].quo <= 31'(ONE_Q30) &&
         stg_ff[ST_DIV_LAST].dv[1].quo <= 31'(ONE_Q30) &&
         stg_ff[ST_DIV_LAST].dv[2].quo <= 31'(ONE_Q30))
      else $error("unit axis component above one");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_MAT] && !rdy[ST_MAT] |=> vld_ff[ST_MAT])
      else $error("stalled stage dropped its beat");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

/* verif/rotate_point_about_axis_test.sv */
module rotate_point_about_axis_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_W   = ((9*32+26+7)/8)*8;
   localparam int RSP_W   = ((3*32+7)/8)*8;
   localparam int LATENCY = 30;
   localparam int LIMIT   = 400000;
   localparam longint HOLD_CYCLES = 250;
   localparam longint DEG90  = longint'(90) << 16;
   localparam longint DEG45  = longint'(45) << 16;
   localparam longint DEG360 = longint'(360) << 16;
   localparam longint ONE_Q30 = longint'(1) << 30;
   localparam logic [31:0] CMAX = 32'h7fffffff;
   localparam logic [31:0] CMIN = 32'h80000000;

   typedef struct {
      logic [31:0] coord [9];   // a xyz, b xyz, point xyz
      logic [25:0] angle;
   } rotation_item_type;

   typedef struct {
      logic [31:0] rot [3];
      logic        degen;
   } rotated_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   rotation_item_type pending_items [$];
   rotated_point_type expected_points [$];
   int  error_count = 0;
   int  accepted_count = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   longint hold_left = 0;
   bit  hold_done = 1'b0;
   longint cycle_count = 0;

   rotate_point_about_axis u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint mulq_q30(longint a, longint b);
      logic [127:0] ua, ub, pr;
      longint r;
      ua = (a < 0) ? 128'(-a) : 128'(a);
      ub = (b < 0) ? 128'(-b) : 128'(b);
      pr = ua * ub + (128'd1 << 29);
      r  = longint'(pr >> 30);
      return ((a < 0) != (b < 0)) ? -r : r;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned res, bt;
      res = 0;
      bt  = 64'd1 << 62;
      while (bt > s) bt >>= 2;
      while (bt != 0) begin
         if (s >= res + bt) begin
            s   = s - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt >>= 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] clamp_coord(longint v);
      if (v > 64'sh7fffffff) return CMAX;
      if (v < -64'sh80000000) return CMIN;
      return v[31:0];
   endfunction

   function automatic rotated_point_type rotate_expect(rotation_item_type it);
      rotated_point_type res;
      longint a [3], d [3], v [3], u [3], m [3][3], acc;
      longint unsigned e [3], mx, sum, n, q, kr;
      longint ang, quad, f, t, sn, cs, s, c, tmp, oc, t2, st, ct, ds, dc;
      longint xx, yy, zz, xy, xz, yz, sx, sy, sz;
      for (int i = 0; i < 3; i++) begin
         a[i] = longint'($signed(it.coord[i]));
         d[i] = longint'($signed(it.coord[3+i])) - a[i];
         v[i] = longint'($signed(it.coord[6+i])) - a[i];
         e[i] = (d[i] < 0) ? -d[i] : d[i];
      end
      mx = e[0];
      if (e[1] > mx) mx = e[1];
      if (e[2] > mx) mx = e[2];
      if (mx == 0) begin
         for (int i = 0; i < 3; i++) res.rot[i] = it.coord[6+i];
         res.degen = 1'b1;
         return res;
      end
      while (mx >= (64'd1 << 31)) begin
         mx >>= 1;
         for (int i = 0; i < 3; i++) e[i] >>= 1;
      end
      while (mx < (64'd1 << 30)) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) e[i] <<= 1;
      end
      sum = e[0]*e[0] + e[1]*e[1] + e[2]*e[2];
      n = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((e[i] << 30) + n / 2) / n;
         u[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
      end

      ang = longint'($signed(it.angle)) % DEG360;
      if (ang < 0) ang += DEG360;
      quad = ang / DEG90;
      f = ang - quad * DEG90;
      t = (f > DEG45) ? DEG90 - f : f;
      kr = ((64'h3243F6A8885A308D / 180) + (64'd1 << 19)) >> 20;
      t = longint'((longint'(t) * kr + (64'd1 << 25)) >> 26);
      // taylor series of sin and cos
      t2 = mulq_q30(t, t);
      st = t; sn = t; ct = ONE_Q30; cs = ONE_Q30;
      for (longint k = 1; k <= 6; k++) begin
         ds = (2*k) * (2*k + 1);
         dc = (2*k - 1) * (2*k);
         st = (mulq_q30(st, t2) + ds / 2) / ds;
         ct = (mulq_q30(ct, t2) + dc / 2) / dc;
         if (k % 2 == 1) begin
            sn -= st; cs -= ct;
         end else begin
            sn += st; cs += ct;
         end
      end
      if (f > DEG45) begin
         tmp = sn; sn = cs; cs = tmp;
      end
      case (quad % 4)
         0: begin s = sn;  c = cs;  end
         1: begin s = cs;  c = -sn; end
         2: begin s = -sn; c = -cs; end
         default: begin s = -cs; c = sn; end
      endcase

      oc = ONE_Q30 - c;
      xx = mulq_q30(mulq_q30(oc, u[0]), u[0]);
      yy = mulq_q30(mulq_q30(oc, u[1]), u[1]);
      zz = mulq_q30(mulq_q30(oc, u[2]), u[2]);
      xy = mulq_q30(mulq_q30(oc, u[0]), u[1]);
      xz = mulq_q30(mulq_q30(oc, u[0]), u[2]);
      yz = mulq_q30(mulq_q30(oc, u[1]), u[2]);
      sx = mulq_q30(s, u[0]); sy = mulq_q30(s, u[1]); sz = mulq_q30(s, u[2]);
      m[0][0] = c + xx;  m[0][1] = xy - sz; m[0][2] = xz + sy;
      m[1][0] = xy + sz; m[1][1] = c + yy;  m[1][2] = yz - sx;
      m[2][0] = xz - sy; m[2][1] = yz + sx; m[2][2] = c + zz;
      for (int i = 0; i < 3; i++) begin
         acc = a[i];
         for (int j = 0; j < 3; j++) acc += mulq_q30(m[i][j], v[j]);
         res.rot[i] = clamp_coord(acc);
      end
      res.degen = 1'b0;
      return res;
   endfunction

   function automatic logic [REQ_W-1:0] pack_item(rotation_item_type it);
      logic [REQ_W-1:0] w;
      w = '0;
      for (int i = 0; i < 9; i++) w[32*i +: 32] = it.coord[i];
      w[288 +: 26] = it.angle;
      return w;
   endfunction

   function automatic rotation_item_type unpack_item(logic [REQ_W-1:0] w);
      rotation_item_type it;
      for (int i = 0; i < 9; i++) it.coord[i] = w[32*i +: 32];
      it.angle = w[288 +: 26];
      return it;
   endfunction

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000);
         default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      endcase
   endfunction

   function automatic logic [25:0] rand_angle();
      return 26'($signed($urandom_range(0, 47185920)) - 23592960);
   endfunction

   task automatic add_item(logic [31:0] ax, ay, az, bx, by, bz, px, py, pz,
                           logic [25:0] ang);
      rotation_item_type it;
      it.coord = '{ax, ay, az, bx, by, bz, px, py, pz};
      it.angle = ang;
      pending_items.push_back(it);
   endtask

   // sender: one beat per handshake, random gaps between beats
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid && req_tready) begin
            accepted_count <= accepted_count + 1;
            if ($urandom_range(0, 99) < 60) gap_left = 0;
            else if ($urandom_range(0, 99) < 90) gap_left = $urandom_range(1, 3);
            else gap_left = $urandom_range(10, 60);
         end
         if (gap_left == 0 && pending_items.size() > 0) begin
            req_tdata  <= pack_item(pending_items.pop_front());
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end
      end
   end

   // receiver: random stalls, one long hold-off partway through
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!hold_done && accepted_count >= 300) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         if ($urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                     : $urandom_range(1, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // predictor on accepted input beats, checker on accepted result beats
   always @(posedge clock) begin
      rotated_point_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_points.push_back(rotate_expect(unpack_item(req_tdata)));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected result beat %h", $realtime, rsp_tdata);
               error_count++;
            end else begin
               want = expected_points.pop_front();
               for (int i = 0; i < 3; i++)
                  if (rsp_tdata[32*i +: 32] !== want.rot[i]) begin
                     $display("%0t: rotated[%0d] expected %h actual %h", $realtime, i,
                              want.rot[i], rsp_tdata[32*i +: 32]);
                     error_count++;
                  end
               if (rsp_tuser[0] !== want.degen) begin
                  $display("%0t: degenerate_axis expected %b actual %b", $realtime,
                           want.degen, rsp_tuser[0]);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [31:0] p [9];
      int mode;
      // degenerate axis, with point passed through
      add_item(32'h10000, 32'h20000, 32'h30000, 32'h10000, 32'h20000, 32'h30000,
               CMAX, CMIN, 32'h12345, 26'd0);
      add_item(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, 32'h0, 26'h1680000);
      // axis along each direction, quadrant angles
      add_item(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h20000, 32'h30000, 26'd90 << 16);
      add_item(0, 0, 0, 0, 32'h10000, 0, 32'h10000, 32'h20000, 32'h30000, 26'd180 << 16);
      add_item(0, 0, 0, 0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h30000, 26'd270 << 16);
      add_item(0, 0, 0, 0, 0, 32'hffff0000, 32'h10000, 0, 0, 26'd45 << 16);
      add_item(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 0, 0, 26'd0);
      add_item(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 0, 0, 26'd360 << 16);
      add_item(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 0, 0, -(26'd360 << 16));
      add_item(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, -(26'd90 << 16));
      add_item(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 26'h167ffff);
      add_item(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, (26'd135 << 16) + 26'd1);
      // extreme coordinates and saturation
      add_item(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX, 26'd180 << 16);
      add_item(CMAX, CMIN, 0, CMIN, CMAX, 0, CMAX, CMAX, CMAX, 26'd90 << 16);
      add_item(0, 0, 0, 32'h1, 0, 0, CMAX, CMAX, CMIN, 26'd45 << 16);
      add_item(CMAX, CMAX, CMAX, CMAX, CMAX, 32'h7ffffffe, CMIN, CMIN, CMIN, 26'd33 << 16);
      add_item(0, 0, 0, 32'h1, 32'h1, 32'h1, CMAX, 0, 0, 26'd180 << 16);
      for (int k = 0; k < 880; k++) begin
         mode = $urandom_range(0, 2);
         for (int i = 0; i < 9; i++) p[i] = rand_coord(mode);
         if ($urandom_range(0, 29) == 0) begin
            p[3] = p[0]; p[4] = p[1]; p[5] = p[2];
         end
         add_item(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8], rand_angle());
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_points.size() != 0);
      repeat (2 * LATENCY) @(posedge clock);
      if (error_count == 0 && expected_points.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
